>>> hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic signed [31:0] value;
    logic        [15:0] prio;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

>>> hdl/spq_if.sv
// Handshake channels of the sorted priority queue: requests and results.
interface spq_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] item_value;
  logic        [15:0] item_priority;

  modport source (output valid, req_type, item_value, item_priority, input ready);
  modport sink   (input valid, req_type, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] removed_value;
  logic signed [31:0] head_value;
  logic               head_valid;
  logic        [4:0]  occupancy;

  modport source (output valid, status, removed_value, head_value, head_valid, occupancy,
                  input ready);
  modport sink   (input valid, status, removed_value, head_value, head_valid, occupancy,
                  output ready);
endinterface

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_place_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output spq_pkg::entry_t    next_o,
  output logic               place_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // A new entry belongs at or before this slot when the slot is empty or holds a
  // strictly lower priority; equal priorities keep the older entry ahead.
  assign place_o = !valid_i || (entry_q.prio < new_i.prio);

  // Dequeue shifts toward the head; enqueue shifts away from the insertion point.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.remove) begin
      entry_d = right_i;
    end else if (ctrl_i.insert && place_o) begin
      entry_d = left_place_i ? left_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign next_o  = entry_d;

endmodule

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue: a chain of entry cells with a registered result port.
//
// Requests arrive on req_i: req_type selects enqueue (value with priority) or
// dequeue of the head. Every accepted request yields exactly one result item on
// rsp_o with a status, the removed value, the new head value, a head-valid flag
// and the occupancy. Entries are kept sorted by priority, highest first, and
// first in, first out among equal priorities.
// Each cell compares its own priority with the incoming one in parallel, so an
// enqueue or dequeue finishes in the cycle it is accepted; the result item is
// registered and appears in the next cycle. One request is taken per cycle
// while the receiver keeps up. The result register separates the two sides: a
// stalled receiver holds req_i.ready low while a result waits; nothing is lost.
// Reset empties the queue at once (the entry count clears); cell contents are
// not cleared and are never read before they are written.
// An enqueue into a full queue is dropped with a full status; a dequeue of an
// empty queue reports an empty status and leaves the queue unchanged.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          accept;
  logic          is_full, is_empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     cell_q    [DEPTH];
  spq_pkg::entry_t     cell_next [DEPTH];
  logic                cell_place[DEPTH];

  logic               rsp_valid_q;
  logic        [1:0]  status_d;
  logic signed [31:0] removed_d;

  assign accept   = req_i.valid && req_i.ready;
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;

  assign new_entry.value = req_i.item_value;
  assign new_entry.prio  = req_i.item_priority;

  // Decode the request into a chain command and a status.
  always_comb begin
    ctrl      = '0;
    status_d  = spq_pkg::STATUS_OK;
    removed_d = '0;
    count_d   = count_q;
    if (req_i.req_type == spq_pkg::REQ_ENQUEUE) begin
      if (is_full) begin
        status_d = spq_pkg::STATUS_FULL;
      end else begin
        ctrl.insert = accept;
        count_d     = count_q + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = spq_pkg::STATUS_EMPTY;
      end else begin
        ctrl.remove = accept;
        removed_d   = cell_q[0].value;
        count_d     = count_q - CW'(1);
      end
    end
  end

  // Cell chain, fed by neighbors; the ends see the new entry and their own entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            left_place;

    if (i == 0) begin : g_first
      assign left_e     = new_entry;
      assign left_place = 1'b0;
    end else begin : g_mid
      assign left_e     = cell_q[i-1];
      assign left_place = cell_place[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (CW'(i) < count_q),
      .new_i        (new_entry),
      .left_i       (left_e),
      .left_place_i (left_place),
      .right_i      (right_e),
      .entry_o      (cell_q[i]),
      .next_o       (cell_next[i]),
      .place_o      (cell_place[i])
    );
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Result register: filled on accept, emptied when the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_o.status        <= status_d;
      rsp_o.removed_value <= removed_d;
      rsp_o.head_value    <= (count_d != '0) ? cell_next[0].value : 32'sd0;
      rsp_o.head_valid    <= (count_d != '0);
      rsp_o.occupancy     <= 5'(count_d);
    end
  end

  assign rsp_o.valid = rsp_valid_q;

endmodule
